@@ design/kcl_pkg.sv @@
// Package for the keypad code lock controller: field widths, event codes,
// lock modes, the result record and the mode encoding helper.
// No dependencies.
`timescale 1ns / 1ps

package kcl_pkg;

  localparam int CODE_DIGITS_DEF = 4;

  localparam int FuncW   = 3;
  localparam int DigitW  = 4;
  localparam int ByteW   = 8;
  localparam int ModeW   = 2;
  localparam int HeldW   = 3;
  localparam int FailW   = 4;

  localparam logic [FailW-1:0] MAX_FAILURES_RST = 4'd3;
  localparam logic [FailW-1:0] FAIL_SAT         = 4'd15;
  localparam logic [DigitW-1:0] DIGIT_MAX       = 4'd9;
  localparam logic [DigitW-1:0] CODE_RST_DIGIT  = 4'd1;

  // Event codes on func
  localparam logic [FuncW-1:0] FUNC_KEY        = 3'd0;
  localparam logic [FuncW-1:0] FUNC_ENTRY      = 3'd1;
  localparam logic [FuncW-1:0] FUNC_EXIT       = 3'd2;
  localparam logic [FuncW-1:0] FUNC_ALARM_RST  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_PROG_START = 3'd4;
  localparam logic [FuncW-1:0] FUNC_REMOTE_DIG = 3'd5;

  // Remote byte that stands for digit 0
  localparam logic [ByteW-1:0] REMOTE_ZERO = 8'h10;

  // Encoded lock_mode values
  localparam logic [ModeW-1:0] LOCK_IDLE  = 2'd0;
  localparam logic [ModeW-1:0] LOCK_ENTER = 2'd1;
  localparam logic [ModeW-1:0] LOCK_ALARM = 2'd2;
  localparam logic [ModeW-1:0] LOCK_PROG  = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_ENTER = 4'b0010,
    MODE_ALARM = 4'b0100,
    MODE_PROG  = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [ModeW-1:0] lock_mode;
    logic             door_open;
    logic             wrong_code;
    logic             alarm_on;
    logic             entry_led;
    logic [HeldW-1:0] digits_held;
    logic [FailW-1:0] failure_count;
  } result_t;

  function automatic logic [ModeW-1:0] mode_code(mode_e m);
    logic [ModeW-1:0] c;
    case (m)
      MODE_IDLE:  c = LOCK_IDLE;
      MODE_ENTER: c = LOCK_ENTER;
      MODE_ALARM: c = LOCK_ALARM;
      MODE_PROG:  c = LOCK_PROG;
      default:    c = LOCK_IDLE;
    endcase
    return c;
  endfunction

endpackage

@@ design/kcl_if.sv @@
// Valid/ready channel interfaces for lock events and lock results.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

interface kcl_in_if;
  logic                        valid;
  logic                        ready;
  logic [kcl_pkg::FuncW-1:0]   func;
  logic [kcl_pkg::DigitW-1:0]  key_digit;
  logic [kcl_pkg::ByteW-1:0]   remote_byte;

  modport source (output valid, func, key_digit, remote_byte, input ready);
  modport sink   (input valid, func, key_digit, remote_byte, output ready);
endinterface

interface kcl_out_if;
  logic                        valid;
  logic                        ready;
  logic [kcl_pkg::ModeW-1:0]   lock_mode;
  logic                        door_open;
  logic                        wrong_code;
  logic                        alarm_on;
  logic                        entry_led;
  logic [kcl_pkg::HeldW-1:0]   digits_held;
  logic [kcl_pkg::FailW-1:0]   failure_count;

  modport source (output valid, lock_mode, door_open, wrong_code, alarm_on, entry_led,
                  digits_held, failure_count, input ready);
  modport sink   (input valid, lock_mode, door_open, wrong_code, alarm_on, entry_led,
                  digits_held, failure_count, output ready);
endinterface

@@ design/kcl_step.sv @@
// Lock state and per-event update: mode, digit count, failure count,
// entry buffer and stored code. Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_step #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [kcl_pkg::FuncW-1:0]   func_i,
  input  logic [kcl_pkg::DigitW-1:0]  key_digit_i,
  input  logic [kcl_pkg::ByteW-1:0]   remote_byte_i,
  input  logic [kcl_pkg::FailW-1:0]   max_failures_i,
  output kcl_pkg::result_t            result_o
);

  localparam int IdxW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int CntW = (IdxW > kcl_pkg::HeldW) ? IdxW : kcl_pkg::HeldW;
  localparam logic [CntW-1:0] LastIdx = CntW'(CODE_DIGITS - 1);

  kcl_pkg::mode_e                                mode_q, mode_d;
  logic [CntW-1:0]                               cnt_q, cnt_d;
  logic [kcl_pkg::FailW-1:0]                     fail_q, fail_d;
  logic [CODE_DIGITS-1:0][kcl_pkg::DigitW-1:0]   buf_q;
  logic [CODE_DIGITS-1:0][kcl_pkg::DigitW-1:0]   code_q;

  logic                          buf_we, code_we, door, wrong, match, last_digit;
  logic                          rdigit_ok;
  logic [kcl_pkg::DigitW-1:0]    rdigit;
  logic [kcl_pkg::FailW-1:0]     limit, fail_inc;
  logic [IdxW-1:0]               idx;

  assign idx        = cnt_q[IdxW-1:0];
  assign last_digit = (cnt_q == LastIdx);
  assign limit      = (max_failures_i == '0) ? kcl_pkg::FailW'(1) : max_failures_i;
  assign fail_inc   = (fail_q != kcl_pkg::FAIL_SAT) ? fail_q + kcl_pkg::FailW'(1) : fail_q;

  always_comb begin
    rdigit_ok = 1'b0;
    rdigit    = '0;
    if (remote_byte_i inside {[8'h01:8'h09]}) begin
      rdigit_ok = 1'b1;
      rdigit    = remote_byte_i[kcl_pkg::DigitW-1:0];
    end else if (remote_byte_i == kcl_pkg::REMOTE_ZERO) begin
      rdigit_ok = 1'b1;
    end
  end

  // Last digit comes straight from the key, the rest from the buffer
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < CODE_DIGITS; k++) begin
      if (k == CODE_DIGITS - 1) begin
        if (key_digit_i != code_q[k]) match = 1'b0;
      end else begin
        if (buf_q[k] != code_q[k]) match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    fail_d  = fail_q;
    door    = 1'b0;
    wrong   = 1'b0;
    buf_we  = 1'b0;
    code_we = 1'b0;
    if (func_i == kcl_pkg::FUNC_ALARM_RST) begin
      mode_d = kcl_pkg::MODE_IDLE;
      cnt_d  = '0;
    end else begin
      case (mode_q)
        kcl_pkg::MODE_IDLE: begin
          if (func_i == kcl_pkg::FUNC_ENTRY) begin
            mode_d = kcl_pkg::MODE_ENTER;
            cnt_d  = '0;
          end else if (func_i == kcl_pkg::FUNC_EXIT) begin
            door   = 1'b1;
            cnt_d  = '0;
            fail_d = '0;
          end else if (func_i == kcl_pkg::FUNC_PROG_START) begin
            mode_d = kcl_pkg::MODE_PROG;
            cnt_d  = '0;
          end
        end
        kcl_pkg::MODE_ENTER: begin
          if (func_i == kcl_pkg::FUNC_KEY && key_digit_i <= kcl_pkg::DIGIT_MAX) begin
            buf_we = 1'b1;
            if (last_digit) begin
              cnt_d = '0;
              if (match) begin
                door   = 1'b1;
                fail_d = '0;
                mode_d = kcl_pkg::MODE_IDLE;
              end else begin
                wrong = 1'b1;
                if (fail_inc >= limit) begin
                  fail_d = '0;
                  mode_d = kcl_pkg::MODE_ALARM;
                end else begin
                  fail_d = fail_inc;
                end
              end
            end else begin
              cnt_d = cnt_q + CntW'(1);
            end
          end
        end
        kcl_pkg::MODE_PROG: begin
          if (func_i == kcl_pkg::FUNC_REMOTE_DIG && rdigit_ok) begin
            code_we = 1'b1;
            if (last_digit) begin
              cnt_d  = '0;
              mode_d = kcl_pkg::MODE_IDLE;
            end else begin
              cnt_d = cnt_q + CntW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_o.lock_mode     = kcl_pkg::mode_code(mode_d);
    result_o.door_open     = door;
    result_o.wrong_code    = wrong;
    result_o.alarm_on      = (mode_d == kcl_pkg::MODE_ALARM);
    result_o.entry_led     = (mode_d == kcl_pkg::MODE_ENTER) || (mode_d == kcl_pkg::MODE_PROG);
    result_o.digits_held   = cnt_d[kcl_pkg::HeldW-1:0];
    result_o.failure_count = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= kcl_pkg::MODE_IDLE;
      cnt_q  <= '0;
      fail_q <= '0;
      code_q <= {CODE_DIGITS{kcl_pkg::CODE_RST_DIGIT}};
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      fail_q <= fail_d;
      if (code_we) code_q[idx] <= rdigit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && buf_we) buf_q[idx] <= key_digit_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) < CODE_DIGITS)
    else $error("digit count reached code length");

  a_code_only_in_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(code_q) |-> ($past(mode_q) == kcl_pkg::MODE_PROG))
    else $error("stored code changed outside programming");

endmodule

@@ design/keypad_code_lock_controller.sv @@
// Keypad code lock controller, top level: configuration register, event
// update and the result register. Depends on kcl_pkg, kcl_if, kcl_step.
`timescale 1ns / 1ps

// Each event beat yields one result beat; an event can be taken every cycle, and
// its result appears in the next cycle from the result register, which also
// decouples the two sides: a new event is taken whenever that register is
// empty or being drained in the same cycle. The whole update (mode change, digit
// collection and the compare of the full entered code) is combinational ahead of
// the result register. The user must write max_failures via cfg_we_i/cfg_wdata_i
// only while no beat is in flight; the block does not check. A value of 0 acts as 1.
module keypad_code_lock_controller #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kcl_pkg::FailW-1:0]   cfg_wdata_i,
  kcl_in_if.sink                      in_i,
  kcl_out_if.source                   out_o
);

  logic [kcl_pkg::FailW-1:0] max_failures_q;
  logic                      out_valid_q;
  kcl_pkg::result_t          res_q, res_d;
  logic                      accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_failures_q <= kcl_pkg::MAX_FAILURES_RST;
    end else if (cfg_we_i) begin
      max_failures_q <= cfg_wdata_i;
    end
  end

  kcl_step #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .func_i         (in_i.func),
    .key_digit_i    (in_i.key_digit),
    .remote_byte_i  (in_i.remote_byte),
    .max_failures_i (max_failures_q),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.lock_mode     = res_q.lock_mode;
  assign out_o.door_open     = res_q.door_open;
  assign out_o.wrong_code    = res_q.wrong_code;
  assign out_o.alarm_on      = res_q.alarm_on;
  assign out_o.entry_led     = res_q.entry_led;
  assign out_o.digits_held   = res_q.digits_held;
  assign out_o.failure_count = res_q.failure_count;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted event produced no result beat");

  a_door_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.door_open) |->
      (res_q.lock_mode == kcl_pkg::LOCK_IDLE && !res_q.wrong_code))
    else $error("door release outside idle or with wrong code");

  a_alarm_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.alarm_on == (res_q.lock_mode == kcl_pkg::LOCK_ALARM)))
    else $error("alarm output disagrees with mode");

  a_alarm_clears_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.wrong_code && res_q.alarm_on) |-> (res_q.failure_count == '0))
    else $error("failure count kept when alarm raised");

endmodule
